/* rtl/leb_pkg.sv */
// leb_pkg: shared types and constants for the LEB128 checked decoder.
// Holds the decoder state struct, the step result struct and status codes.
// No dependencies.
`timescale 1ns / 1ps

package leb_pkg;

    localparam int ValueWidth = 64;
    localparam int GroupBits  = 7;

    localparam logic [6:0] MaxBits    = 7'd64;
    localparam logic [6:0] GroupMask  = 7'h7f;
    localparam logic [6:0] GroupZero  = 7'h00;
    localparam logic [6:0] GroupStep  = 7'd7;
    localparam logic [6:0] ShiftLimit = 7'd64;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_TRUNC = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [ValueWidth-1:0] accumulator;
        logic [6:0]            shift_amount;
        logic                  in_value;
        logic [6:0]            latched_bits;
        logic                  latched_signed;
        logic                  negative_flag;
    } leb_state_t;

    typedef struct packed {
        logic                  emit;
        logic [ValueWidth-1:0] value;
        status_t               status;
    } leb_result_t;

endpackage

/* rtl/leb_step.sv */
// leb_step: combinational next-state and result logic for one encoded byte.
// Depends on leb_pkg for the state and result structs and status codes.
`timescale 1ns / 1ps

module leb_step (
    input  leb_pkg::leb_state_t  cur,
    input  logic                 check_en,
    input  logic [7:0]           data_byte,
    input  logic [6:0]           value_bits,
    input  logic                 signed_mode,
    input  logic                 buffer_end,
    output leb_pkg::leb_state_t  nxt,
    output leb_pkg::leb_result_t res
);
    import leb_pkg::*;

    logic                  fresh;
    logic                  more;
    logic [6:0]            grp;
    logic [6:0]            lb;
    logic                  ls;
    logic [ValueWidth-1:0] acc;
    logic [6:0]            sh;
    logic                  neg;
    logic                  neg1;
    logic                  neg2;
    logic [6:0]            left;
    logic [2:0]            left_lo;
    logic [6:0]            mask;
    logic [6:0]            probe;
    logic                  range_err;
    logic [ValueWidth-1:0] acc1;
    logic [6:0]            sh1;
    logic [ValueWidth-1:0] ext;

    always_comb
    begin
        fresh = !cur.in_value;
        more  = data_byte[7];
        grp   = data_byte[6:0];
        lb    = fresh ? ((value_bits > MaxBits) ? MaxBits : value_bits) : cur.latched_bits;
        ls    = fresh ? signed_mode : cur.latched_signed;
        acc   = fresh ? '0 : cur.accumulator;
        sh    = fresh ? 7'd0 : cur.shift_amount;
        neg   = fresh ? 1'b0 : cur.negative_flag;

        // range check on the current group
        left    = lb - sh;
        left_lo = left[2:0];
        mask    = '0;
        probe   = grp;
        range_err = 1'b0;
        neg1    = neg;
        if (check_en)
        begin
            if (sh >= lb)
            begin
                range_err = (grp != (neg ? GroupMask : GroupZero));
            end
            else
            begin
                if (ls)
                begin
                    neg1 = grp[6];
                end
                if (left < GroupStep)
                begin
                    if (ls)
                    begin
                        mask  = GroupMask << (left_lo - 3'd1);
                        probe = neg1 ? ~grp : grp;
                    end
                    else
                    begin
                        mask  = GroupMask << left_lo;
                        probe = grp;
                    end
                    range_err = ((probe & mask) != GroupZero);
                end
            end
        end

        // accumulate, saturating the shift at the top of the word
        if (sh < ShiftLimit)
        begin
            acc1 = acc | ({{(ValueWidth-GroupBits){1'b0}}, grp} << sh[5:0]);
            sh1  = sh + GroupStep;
        end
        else
        begin
            acc1 = acc;
            sh1  = sh;
        end

        neg2 = (!check_en && ls) ? data_byte[6] : neg1;
        ext  = (neg2 && (sh1 < ShiftLimit)) ? ({ValueWidth{1'b1}} << sh1[5:0]) : '0;

        nxt.accumulator    = acc1;
        nxt.shift_amount   = sh1;
        nxt.in_value       = 1'b1;
        nxt.latched_bits   = lb;
        nxt.latched_signed = ls;
        nxt.negative_flag  = neg1;
        res.emit   = 1'b0;
        res.value  = '0;
        res.status = STATUS_OK;

        priority if (fresh && !more)
        begin
            nxt.accumulator   = '0;
            nxt.shift_amount  = 7'd0;
            nxt.negative_flag = 1'b0;
            nxt.in_value      = 1'b0;
            res.emit   = 1'b1;
            res.value  = {{(ValueWidth-GroupBits){ls & grp[6]}}, grp};
        end
        else if (range_err)
        begin
            nxt.accumulator  = acc;
            nxt.shift_amount = sh;
            nxt.in_value     = 1'b0;
            res.emit   = 1'b1;
            res.status = STATUS_RANGE;
        end
        else if (!more)
        begin
            nxt.negative_flag = neg2;
            nxt.in_value      = 1'b0;
            res.emit   = 1'b1;
            res.value  = acc1 | ext;
        end
        else if (check_en && (buffer_end || (sh1 >= lb)))
        begin
            nxt.in_value = 1'b0;
            res.emit   = 1'b1;
            res.status = STATUS_TRUNC;
        end
        else
        begin
            res.emit = 1'b0;
        end
    end

endmodule

/* rtl/leb128_checked_decoder.sv */
// leb128_checked_decoder: top level of the LEB128 checked byte-stream decoder.
// Depends on leb_pkg and leb_step.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall): one encoded byte per word with the
//   target width, signedness and buffer-end flag. A word is taken on a rising
//   edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one word with value and status for
//   each finished value or detected error; bytes in the middle of a value give
//   no output word.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes check_enable;
//   cfg_ready is always high. Write only while the decoder is idle.
//   The result word appears in the cycle after the byte that ends the value.
//   Throughput: one byte per cycle while in_stall is low, set by the single
//   decode stage between the byte input and the output register.
//   Reset: clears the decoder state, empties the output register and sets
//   check_enable to 1.
//   Stall: while a result waits under out_stall, in_stall is raised; when the
//   output register drains or is empty, a new byte is taken every cycle.
module leb128_checked_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                data_byte,
    input  logic [6:0]                value_bits,
    input  logic                      signed_mode,
    input  logic                      buffer_end,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [leb_pkg::ValueWidth-1:0] value,
    output leb_pkg::status_t          status
);
    import leb_pkg::*;

    leb_state_t            state_reg;
    leb_state_t            state_next;
    leb_result_t           step_res;
    logic                  check_enable_reg;
    logic                  out_valid_reg;
    logic [ValueWidth-1:0] value_reg;
    status_t               status_reg;
    logic                  in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & !in_stall;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    leb_step u_step (
        .cur         (state_reg),
        .check_en    (check_enable_reg),
        .data_byte   (data_byte),
        .value_bits  (value_bits),
        .signed_mode (signed_mode),
        .buffer_end  (buffer_end),
        .nxt         (state_next),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            check_enable_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && step_res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && step_res.emit)
        begin
            value_reg  <= step_res.value;
            status_reg <= step_res.status;
        end
    end

    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_OK)) |-> (value_reg == '0))
        else $error("error result carries nonzero value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((status_reg == STATUS_OK) || (status_reg == STATUS_TRUNC) ||
                           (status_reg == STATUS_RANGE)))
        else $error("illegal status code");

    a_emit_ends_value: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && step_res.emit) |=> !state_reg.in_value)
        else $error("decoder still inside a value after a result");

    a_bits_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.in_value |-> (state_reg.latched_bits <= MaxBits))
        else $error("latched width above 64");

    a_shift_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.shift_amount <= (ShiftLimit + GroupStep - 7'd1))
        else $error("shift ran past saturation");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for leb128_checked_decoder: byte words in, decoded words out.
// It predicts each result from a behavioral model of the decoder and checks it.
// Depends on leb_pkg and the leb128_checked_decoder RTL.
`timescale 1ns / 1ps

module testbench;

    import leb_pkg::*;

    localparam int IdleLimit = 4000;

    typedef struct {
        logic [63:0] value;
        status_t     status;
    } decode_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic [6:0]  value_bits = 7'd0;
    logic        signed_mode = 1'b0;
    logic        buffer_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] value;
    status_t     status;

    // predictor state
    logic        check_on = 1'b1;
    logic [63:0] dec_acc = '0;
    logic [6:0]  dec_shift = '0;
    logic        dec_busy = 1'b0;
    logic [6:0]  dec_bits = '0;
    logic        dec_signed = 1'b0;
    logic        dec_neg = 1'b0;

    decode_result_t expected_decodes[$];
    decode_result_t head;
    logic [7:0]     enc_bytes[$];

    int          err_count = 0;
    int          bytes_sent = 0;
    int          words_seen = 0;
    int          status_count[0:2] = '{0, 0, 0};
    int          idle_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned stall_roll;
    logic        stall_quiet = 1'b0;
    logic        gap_quiet = 1'b0;

    leb128_checked_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .value_bits  (value_bits),
        .signed_mode (signed_mode),
        .buffer_end  (buffer_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .status      (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic leb_decode_byte(input logic [7:0] b, input logic [6:0] bits,
                                             input logic sgn, input logic last,
                                             output logic [63:0] val, output status_t st);
        logic [6:0]  grp;
        logic [6:0]  left;
        logic [6:0]  probe;
        logic [7:0]  mask;
        int unsigned limit;
        int unsigned count;
        val = '0;
        st = STATUS_OK;
        if (!dec_busy)
        begin
            dec_bits = (bits > MaxBits) ? MaxBits : bits;
            dec_signed = sgn;
            dec_acc = '0;
            dec_shift = '0;
            dec_neg = 1'b0;
            if (!b[7])
            begin
                val = {56'b0, b};
                if (sgn && b[6])
                    val[63:6] = '1;
                return 1'b1;
            end
            dec_busy = 1'b1;
        end
        grp = b[6:0];
        if (check_on)
        begin
            if (dec_shift >= dec_bits)
            begin
                if (grp != (dec_neg ? GroupMask : GroupZero))
                begin
                    dec_busy = 1'b0;
                    st = STATUS_RANGE;
                    return 1'b1;
                end
            end
            else
            begin
                left = dec_bits - dec_shift;
                if (dec_signed)
                    dec_neg = grp[6];
                if (left < GroupStep)
                begin
                    if (dec_signed)
                    begin
                        mask = 8'hff << (left - 7'd1);
                        probe = dec_neg ? ~grp : grp;
                    end
                    else
                    begin
                        mask = 8'hff << left;
                        probe = grp;
                    end
                    if (({1'b0, probe} & mask) != 8'h00)
                    begin
                        dec_busy = 1'b0;
                        st = STATUS_RANGE;
                        return 1'b1;
                    end
                end
            end
        end
        if (dec_shift < ShiftLimit)
        begin
            dec_acc |= {57'b0, grp} << dec_shift;
            dec_shift += GroupStep;
        end
        if (!b[7])
        begin
            val = dec_acc;
            if (!check_on && dec_signed)
                dec_neg = b[6];
            if (dec_neg && dec_shift < ShiftLimit)
                val |= {64{1'b1}} << dec_shift;
            dec_busy = 1'b0;
            return 1'b1;
        end
        if (check_on)
        begin
            limit = (dec_bits + 32'd6) / 32'd7;
            count = dec_shift / GroupStep;
            if (last || count >= limit)
            begin
                dec_busy = 1'b0;
                st = STATUS_TRUNC;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void leb_encode(input logic [63:0] v, input logic sgn, input int pad);
        logic [63:0] rest;
        logic [7:0]  b;
        logic        more;
        enc_bytes.delete();
        rest = v;
        more = 1'b1;
        while (more)
        begin
            b = {1'b0, rest[6:0]};
            if (sgn)
            begin
                rest = $signed(rest) >>> 7;
                more = !((rest == '0 && !b[6]) || (rest == '1 && b[6]));
            end
            else
            begin
                rest = rest >> 7;
                more = (rest != '0);
            end
            b[7] = more;
            enc_bytes.push_back(b);
        end
        repeat (pad)
        begin
            enc_bytes[enc_bytes.size() - 1] = enc_bytes[enc_bytes.size() - 1] | 8'h80;
            enc_bytes.push_back((sgn && v[63]) ? 8'h7f : 8'h00);
        end
    endfunction

    function automatic logic [63:0] pick_value(input logic [6:0] w, input logic sgn);
        logic [63:0] mask;
        logic [63:0] raw;
        mask = (w >= MaxBits) ? '1 : ((64'd1 << w) - 64'd1);
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: raw = '0;
            1: raw = sgn ? (mask >> 1) : mask;
            2: raw = sgn ? ~(mask >> 1) : '1;
            3: raw = raw & 64'h3fff;
            4: raw = '1;
            default: ;
        endcase
        raw &= mask;
        if (sgn && raw[w - 1])
            raw |= ~mask;
        return raw;
    endfunction

    function automatic logic [6:0] pick_width();
        logic [6:0] common[13] = '{1, 7, 8, 14, 16, 21, 28, 32, 33, 49, 56, 63, 64};
        int         r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return common[$urandom_range(0, 12)];
        else if (r < 88)
            return 7'($urandom_range(1, 64));
        else if (r < 93)
            return 7'd0;
        return 7'($urandom_range(65, 127));
    endfunction

    function automatic int pick_gap();
        int r;
        if (gap_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // out_stall pattern: mostly short bursts, some long holds, quiet stretches on request
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (!stall_quiet && stall_roll < 30)
            begin
                out_stall <= 1'b1;
                stall_left <= (stall_roll < 3) ? $urandom_range(20, 80) : $urandom_range(0, 4);
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_decodes.size() == 0)
            begin
                $error("unexpected word: value %h status %0d", value, status);
                err_count++;
            end
            else
            begin
                head = expected_decodes.pop_front();
                words_seen++;
                if (value !== head.value)
                begin
                    $error("value: expected %h, got %h", head.value, value);
                    err_count++;
                end
                if (status !== head.status)
                begin
                    $error("status: expected %0d, got %0d", head.status, status);
                    err_count++;
                end
                if (head.status <= STATUS_RANGE)
                    status_count[head.status]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("[leb128_checked_decoder] ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [6:0] bits,
                             input logic sgn, input logic last);
        logic [63:0]    pv;
        status_t        ps;
        decode_result_t res;
        int             gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        value_bits <= bits;
        signed_mode <= sgn;
        buffer_end <= last;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        if (leb_decode_byte(b, bits, sgn, last, pv, ps))
        begin
            res.value = pv;
            res.status = ps;
            expected_decodes.push_back(res);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_decodes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_check_enable(input logic en);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= en;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        check_on = en;
    endtask

    // later bytes carry random width and sign fields, which must be ignored
    task automatic send_encoded(input logic [6:0] w, input logic sgn, input int cut);
        int   i;
        logic last;
        for (i = 0; i < enc_bytes.size(); i++)
        begin
            if (i == cut)
                last = 1'b1;
            else
                last = (i == enc_bytes.size() - 1) ? 1'($urandom_range(0, 1)) : 1'b0;
            if (i == 0)
                send_byte(enc_bytes[i], w, sgn, last);
            else
                send_byte(enc_bytes[i], 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), last);
            if (i == cut)
                break;
        end
    endtask

    task automatic send_random_sequence();
        logic [6:0]  w;
        logic [6:0]  eff;
        logic        sgn;
        logic [63:0] v;
        int          pick;
        int          n;
        int          i;
        int          cut;
        w = pick_width();
        sgn = $urandom_range(0, 1);
        eff = (w == 0) ? 7'd1 : ((w > MaxBits) ? MaxBits : w);
        pick = $urandom_range(0, 99);
        if (pick < 88)
        begin
            v = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : pick_value(eff, sgn);
            leb_encode(v, sgn, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
            cut = -1;
            if (pick >= 70 && pick < 80 && enc_bytes.size() > 1)
                cut = $urandom_range(0, enc_bytes.size() - 2);
            if (pick >= 80)
            begin
                i = $urandom_range(0, enc_bytes.size() - 1);
                enc_bytes[i] = enc_bytes[i] ^ (8'h01 << $urandom_range(0, 7));
            end
            send_encoded(w, sgn, cut);
        end
        else if (pick < 94)
        begin
            // long run: can push the shift past bit 63
            n = $urandom_range(9, 13);
            for (i = 0; i < n; i++)
                send_byte({i != n - 1, 7'($urandom_range(0, 127))}, w, sgn, 1'($urandom_range(0, 1)));
        end
        else
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                send_byte(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 39) == 0)
            wait_drained();
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_sequence();
    endtask

    task automatic test_single_byte();
        write_check_enable(1'b1);
        send_byte(8'h00, 7'd64, 1'b0, 1'b0);
        send_byte(8'h7f, 7'd1, 1'b0, 1'b1);
        send_byte(8'h40, 7'd64, 1'b1, 1'b0);
        send_byte(8'h3f, 7'd8, 1'b1, 1'b1);
        send_byte(8'h7f, 7'd0, 1'b1, 1'b0);
    endtask

    task automatic test_extremes();
        // most negative 64-bit value, width above 64 clamps to 64
        leb_encode(64'h8000_0000_0000_0000, 1'b1, 0);
        send_encoded(7'd100, 1'b1, -1);
    endtask

    task automatic test_range_errors();
        leb_encode(64'h0000_0001_0fff_ffff, 1'b0, 0);
        send_encoded(7'd32, 1'b0, -1);
    endtask

    task automatic test_truncation();
        send_byte(8'h81, 7'd16, 1'b0, 1'b0);
        send_byte(8'h82, 7'd16, 1'b0, 1'b1);
        send_byte(8'h80, 7'd0, 1'b0, 1'b0);
        send_byte(8'h80, 7'd8, 1'b0, 1'b0);
        send_byte(8'h80, 7'd8, 1'b0, 1'b0);
    endtask

    task automatic test_check_toggle();
        send_byte(8'h80, 7'd8, 1'b0, 1'b0);
        write_check_enable(1'b0);
        send_byte(8'h80, 7'd8, 1'b0, 1'b1);
        send_byte(8'h80, 7'd8, 1'b0, 1'b1);
        send_byte(8'h01, 7'd8, 1'b0, 1'b0);
        write_check_enable(1'b1);
    endtask

    task automatic test_random_checked();
        write_check_enable(1'b1);
        run_random(450);
    endtask

    task automatic test_random_unchecked();
        write_check_enable(1'b0);
        run_random(300);
    endtask

    task automatic test_random_mixed();
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            write_check_enable(phase[0]);
            gap_quiet = (phase == 2);
            stall_quiet = (phase == 3);
            run_random(110);
        end
        gap_quiet = 1'b0;
        stall_quiet = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_byte();
        test_extremes();
        test_range_errors();
        test_truncation();
        test_check_toggle();
        test_random_checked();
        test_random_unchecked();
        test_random_mixed();
        wait_drained();
        repeat (4) @(posedge clk);
        $display("Sent %0d bytes, checked %0d words: %0d ok, %0d truncated, %0d out of range.",
                 bytes_sent, words_seen, status_count[0], status_count[1], status_count[2]);
        $display("Widths 0 to 127, signed and unsigned, checks on and off, shift past bit 63.");
        if (err_count == 0)
            $display("[leb128_checked_decoder] OK");
        else
            $display("[leb128_checked_decoder] ERROR");
        $finish;
    end

endmodule
